// ----- hdl/mvac_pkg.sv -----
// ----------------------------------------------------------------------------
// Motor valve actuator controller package
// Shared types, codes and reset values for the valve controller.
// ----------------------------------------------------------------------------
package mvac_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_OPENING = 3'd1,
		MODE_CLOSING = 3'd2,
		MODE_OPEN    = 3'd3,
		MODE_CLOSED  = 3'd4,
		MODE_FAULT   = 3'd5
	} mode_t;

	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_OPEN  = 3'd1;
	localparam logic [2:0] OP_CLOSE = 3'd2;
	localparam logic [2:0] OP_STOP  = 3'd3;
	localparam logic [2:0] OP_EMERG = 3'd4;

	localparam logic [5:0] FLAG_OPEN    = 6'h01;
	localparam logic [5:0] FLAG_CLOSED  = 6'h02;
	localparam logic [5:0] FLAG_MOVING  = 6'h04;
	localparam logic [5:0] FLAG_FAULT   = 6'h08;
	localparam logic [5:0] FLAG_OVERCUR = 6'h10;
	localparam logic [5:0] FLAG_TIMEOUT = 6'h20;

	localparam logic [1:0] DRIVE_OFF   = 2'd0;
	localparam logic [1:0] DRIVE_OPEN  = 2'd1;
	localparam logic [1:0] DRIVE_CLOSE = 2'd2;

	localparam logic [1:0] REG_MOVE_TIMEOUT  = 2'd0;
	localparam logic [1:0] REG_OC_LIMIT      = 2'd1;
	localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd2;
	localparam logic [1:0] REG_CURRENT_SCALE = 2'd3;

	localparam logic [15:0] MOVE_TIMEOUT_RST  = 16'd3000;
	localparam logic [15:0] OC_LIMIT_RST      = 16'd2000;
	localparam logic [7:0]  SAMPLE_PERIOD_RST = 8'd5;
	localparam logic [7:0]  CURRENT_SCALE_RST = 8'd65;
	localparam logic [7:0]  SINCE_SAMPLE_RST  = 8'hFF;

	localparam int unsigned IN_BITS  = 17;
	localparam int unsigned IN_BYTES = (IN_BITS + 7) / 8;
	localparam int unsigned OUT_BITS  = 27;
	localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;

	typedef struct packed {
		logic [15:0] move_timeout_ticks;
		logic [15:0] overcurrent_limit_ma;
		logic [7:0]  sample_period_ticks;
		logic [7:0]  current_scale;
	} cfg_t;

	typedef struct packed {
		logic signed [11:0] adc_sample;
		logic               at_closed_limit;
		logic               at_open_limit;
		logic [2:0]         operation;
	} item_t;

	typedef struct packed {
		logic        started;
		mode_t       mode;
		logic [5:0]  flags;
		logic [15:0] last_ma;
		logic [15:0] move_elapsed;
		logic [7:0]  since_sample;
	} vstate_t;

	typedef struct packed {
		logic [1:0]  drive_direction;
		logic [15:0] motor_current_ma;
		logic [5:0]  status_bits;
		mode_t       valve_mode;
	} result_t;

endpackage

// ----- hdl/motor_valve_actuator_controller.sv -----
// ----------------------------------------------------------------------------
// Motor valve actuator controller
// Per-tick valve state machine with limit switches, current sampling,
// timeout and overcurrent faults, and H-bridge drive output.
// ----------------------------------------------------------------------------
// Pipeline: the edge that accepts a request loads the input register, and its result
// moves into the result register once that is free or being drained, offered from then.
// Throughput: one request per cycle while m_axis_tready drains the results; the
// valve state updates as each request moves from the input register to the result register.
// Reset: arst_n clears the pipeline, returns the valve state to its start-up
// values and the configuration registers to their defaults; no clearing pass.
module motor_valve_actuator_controller (
	input  logic        clk,
	input  logic        arst_n,
	// APB-style configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// tick requests
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [2:0] operation, [3] at_open_limit, [4] at_closed_limit,
	// [16:5] adc_sample, [23:17] zero
	input  logic [8*mvac_pkg::IN_BYTES-1:0]  s_axis_tdata,
	// results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] valve_mode, [8:3] status_bits, [24:9] motor_current_ma,
	// [26:25] drive_direction, [31:27] zero
	output logic [8*mvac_pkg::OUT_BYTES-1:0] m_axis_tdata
);
	import mvac_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	vstate_t state_q;
	vstate_t state_nxt;
	result_t res_nxt;
	logic    in_take;
	logic    advance;

	mvac_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mvac_core u_core (
		.cur  (state_q),
		.item (item_s1),
		.cfg  (cfg),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Advance the held request whenever the result register is free or
	// being drained; the input register refills in the same cycle.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take)      valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;

			if (advance)            valid_s2 <= 1'b1;
			else if (m_axis_tready) valid_s2 <= 1'b0;
		end
	end

	// Valve state: commit the tick's update as its result is registered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.started      <= 1'b0;
			state_q.mode         <= MODE_IDLE;
			state_q.flags        <= '0;
			state_q.last_ma      <= '0;
			state_q.move_elapsed <= '0;
			state_q.since_sample <= SINCE_SAMPLE_RST;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Payload registers: hold while stalled.
	always_ff @(posedge clk) begin
		if (in_take) item_s1 <= s_axis_tdata[IN_BITS-1:0];
		if (advance) res_s2  <= res_nxt;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(8*OUT_BYTES-OUT_BITS){1'b0}}, res_s2};

endmodule

// ----- hdl/mvac_regs.sv -----
// ----------------------------------------------------------------------------
// Valve controller configuration registers
// APB-style register file holding timeout, current limit, sample period
// and current scale.
// ----------------------------------------------------------------------------
module mvac_regs (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [3:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready,
	output mvac_pkg::cfg_t cfg
);
	import mvac_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr_en;

	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.move_timeout_ticks   <= MOVE_TIMEOUT_RST;
			cfg_q.overcurrent_limit_ma <= OC_LIMIT_RST;
			cfg_q.sample_period_ticks  <= SAMPLE_PERIOD_RST;
			cfg_q.current_scale        <= CURRENT_SCALE_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_MOVE_TIMEOUT:  cfg_q.move_timeout_ticks   <= pwdata[15:0];
				REG_OC_LIMIT:      cfg_q.overcurrent_limit_ma <= pwdata[15:0];
				REG_SAMPLE_PERIOD: cfg_q.sample_period_ticks  <= pwdata[7:0];
				REG_CURRENT_SCALE: cfg_q.current_scale        <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MOVE_TIMEOUT:  prdata = {16'd0, cfg_q.move_timeout_ticks};
			REG_OC_LIMIT:      prdata = {16'd0, cfg_q.overcurrent_limit_ma};
			REG_SAMPLE_PERIOD: prdata = {24'd0, cfg_q.sample_period_ticks};
			REG_CURRENT_SCALE: prdata = {24'd0, cfg_q.current_scale};
			default:           prdata = '0;
		endcase
	end

endmodule

// ----- hdl/mvac_core.sv -----
// ----------------------------------------------------------------------------
// Valve controller tick logic
// Combinational next-state and result for one control tick.
// ----------------------------------------------------------------------------
module mvac_core (
	input  mvac_pkg::vstate_t cur,
	input  mvac_pkg::item_t   item,
	input  mvac_pkg::cfg_t    cfg,
	output mvac_pkg::vstate_t nxt,
	output mvac_pkg::result_t res
);
	import mvac_pkg::*;

	// Enter a mode; re-entering the current mode keeps flags and elapsed count.
	function automatic vstate_t go_mode(vstate_t s, mode_t target);
		vstate_t r;
		r = s;
		if (s.mode != target) begin
			r.mode = target;
			unique case (target)
				MODE_OPENING, MODE_CLOSING: begin
					r.flags = (s.flags & ~(FLAG_OPEN | FLAG_CLOSED | FLAG_FAULT |
						FLAG_OVERCUR | FLAG_TIMEOUT)) | FLAG_MOVING;
					r.move_elapsed = '0;
				end
				MODE_OPEN:   r.flags = (s.flags & ~FLAG_MOVING) | FLAG_OPEN;
				MODE_CLOSED: r.flags = (s.flags & ~FLAG_MOVING) | FLAG_CLOSED;
				MODE_FAULT:  r.flags = (s.flags & ~FLAG_MOVING) | FLAG_FAULT;
				default:     r.flags = s.flags & ~FLAG_MOVING;
			endcase
		end
		return r;
	endfunction

	always_comb begin
		vstate_t     s;
		logic [10:0] counts;
		logic [18:0] ma;
		logic        moving;
		logic        reached;
		logic        lo;
		logic        lc;

		lo = item.at_open_limit;
		lc = item.at_closed_limit;
		s  = cur;

		// first tick: take the mode from the limit switches
		if (!cur.started) begin
			s.started = 1'b1;
			if (lo) begin
				s.mode  = MODE_OPEN;
				s.flags = s.flags | FLAG_OPEN;
			end else if (lc) begin
				s.mode  = MODE_CLOSED;
				s.flags = s.flags | FLAG_CLOSED;
			end else begin
				s.mode = MODE_IDLE;
			end
		end

		unique case (item.operation)
			OP_OPEN:  if (!lo) s = go_mode(s, MODE_OPENING);
			OP_CLOSE: if (!lc) s = go_mode(s, MODE_CLOSING);
			OP_STOP: begin
				if (lo)      s = go_mode(s, MODE_OPEN);
				else if (lc) s = go_mode(s, MODE_CLOSED);
				else         s = go_mode(s, MODE_IDLE);
			end
			OP_EMERG: s = go_mode(s, MODE_CLOSING);
			default: ;
		endcase

		moving = (s.mode == MODE_OPENING) || (s.mode == MODE_CLOSING);

		// negative samples read as zero current
		counts = item.adc_sample[11] ? 11'd0 : item.adc_sample[10:0];
		ma     = {8'd0, counts} * {11'd0, cfg.current_scale};
		if (moving && (s.since_sample >= cfg.sample_period_ticks)) begin
			s.last_ma      = (ma > 19'h0FFFF) ? 16'hFFFF : ma[15:0];
			s.since_sample = '0;
		end

		reached = (s.mode == MODE_OPENING) ? lo : lc;
		if (moving) begin
			priority if (reached) begin
				s = go_mode(s, (s.mode == MODE_OPENING) ? MODE_OPEN : MODE_CLOSED);
			end else if (s.move_elapsed > cfg.move_timeout_ticks) begin
				s.flags = s.flags | FLAG_TIMEOUT;
				s = go_mode(s, MODE_FAULT);
			end else if (s.last_ma > cfg.overcurrent_limit_ma) begin
				s.flags = s.flags | FLAG_OVERCUR;
				s = go_mode(s, MODE_FAULT);
			end else begin
				// keep moving
			end
		end

		res.valve_mode       = s.mode;
		res.status_bits      = s.flags;
		res.motor_current_ma = s.last_ma;
		priority if (s.mode == MODE_OPENING) res.drive_direction = DRIVE_OPEN;
		else if (s.mode == MODE_CLOSING)     res.drive_direction = DRIVE_CLOSE;
		else                                 res.drive_direction = DRIVE_OFF;

		// saturating tick counters
		nxt = s;
		if (s.move_elapsed != 16'hFFFF) nxt.move_elapsed = s.move_elapsed + 16'd1;
		if (s.since_sample != 8'hFF)    nxt.since_sample = s.since_sample + 8'd1;
	end

endmodule

// ----- hdl/mvac_checker.sv -----
// ----------------------------------------------------------------------------
// Valve controller port checker
// Watches the result stream for handshake and mode/flag consistency.
// ----------------------------------------------------------------------------
module mvac_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);
	import mvac_pkg::*;

	logic [2:0] mode;
	logic [5:0] status;
	logic [1:0] drive;

	assign mode   = m_axis_tdata[2:0];
	assign status = m_axis_tdata[8:3];
	assign drive  = m_axis_tdata[26:25];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed while stalled");

	a_drive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((drive == DRIVE_OPEN) == (mode == MODE_OPENING)) &&
			((drive == DRIVE_CLOSE) == (mode == MODE_CLOSING)))
		else $error("drive direction disagrees with mode");

	a_moving: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> status[2] == ((mode == MODE_OPENING) || (mode == MODE_CLOSING)))
		else $error("moving flag disagrees with mode");

	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (mode == MODE_FAULT) |-> status[3])
		else $error("fault mode without fault flag");

	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (mode == MODE_OPEN) |-> status[0])
		else $error("open mode without open flag");

endmodule

bind motor_valve_actuator_controller mvac_checker u_mvac_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
